// ===== design/lz78e_pkg.sv =====
// ============================================================================
// LZ78 encoder package
// Shared constants and types for the LZ78 dictionary encoder and its cells.
// ============================================================================
`default_nettype none

package lz78e_pkg;

    localparam int DICT_ENTRIES = 128;
    localparam int IDX_W        = $clog2(DICT_ENTRIES);
    localparam int BYTE_W       = 8;
    localparam int TDATA_IN_W   = ((BYTE_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W  = ((IDX_W + BYTE_W + 7) / 8) * 8;

    // Index of the last entry that may be filled; entry 0 is the root.
    localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(DICT_ENTRIES - 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    // Broadcast from the controller to every dictionary cell.
    typedef struct packed {
        logic              search;
        logic [IDX_W-1:0]  node;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  count;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [IDX_W-1:0]  wr_prefix;
        logic [BYTE_W-1:0] wr_byte;
    } cell_bus_t;

endpackage

`default_nettype wire

// ===== design/lz78e_cell.sv =====
// ============================================================================
// LZ78 dictionary cell
// Holds one dictionary entry, compares it against the search key and merges
// its index into the hit index passed along the row.
// ============================================================================
`default_nettype none

module lz78e_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [lz78e_pkg::IDX_W-1:0]    cell_idx,
    input  wire lz78e_pkg::cell_bus_t           bus,
    input  wire logic [lz78e_pkg::IDX_W-1:0]    hit_in,
    output logic [lz78e_pkg::IDX_W-1:0]         hit_out,
    output logic                                match
);

    logic [lz78e_pkg::IDX_W-1:0]  prefix_reg;
    logic [lz78e_pkg::BYTE_W-1:0] byte_reg;
    logic                         match_reg;
    logic                         match_next;
    logic                         live;

    // Only entries 1..count hold phrases of the current stream.
    assign live = (cell_idx <= bus.count);

    assign match_next = live && (prefix_reg == bus.node) && (byte_reg == bus.data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (bus.search)
        begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bus.wr_en && (bus.wr_idx == cell_idx))
        begin
            prefix_reg <= bus.wr_prefix;
            byte_reg   <= bus.wr_byte;
        end
    end

    // Dictionary pairs are unique, so at most one cell matches and an OR
    // merge along the row yields the hit index.
    assign hit_out = hit_in | (match_reg ? cell_idx : '0);
    assign match   = match_reg;

endmodule

`default_nettype wire

// ===== design/lz78_dictionary_encoder.sv =====
// ============================================================================
// LZ78 dictionary encoder
// Row of dictionary cells searched in parallel with a small update controller.
// ============================================================================
// A byte is accepted only in the idle state. The cells compare on the accept edge, and
// the update state then writes the entry, updates the node and registers any token,
// after which the encoder returns to idle and can take the next byte.
// A byte that produces a token holds its update cycle while an earlier token is unread.
// Reset clears the state, node, entry count and output valid; entry contents
// are not cleared, since the count alone decides which cells are searched.
`default_nettype none

module lz78_dictionary_encoder (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // [7:0] data_byte
    input  wire logic [lz78e_pkg::TDATA_IN_W-1:0]       s_tdata,
    input  wire logic                                   s_tlast,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // [6:0] prefix_index, [14:7] next_byte, [15] zero
    output logic [lz78e_pkg::TDATA_OUT_W-1:0]           m_tdata,
    // [0] has_byte
    output logic                                        m_tuser,
    output logic                                        m_tlast
);

    localparam int D = lz78e_pkg::DICT_ENTRIES;
    localparam int W = lz78e_pkg::IDX_W;
    localparam int B = lz78e_pkg::BYTE_W;

    lz78e_pkg::state_t state_reg, state_next;

    logic [W-1:0] node_reg, node_next;
    logic [W-1:0] count_reg, count_next;
    logic [B-1:0] byte_reg;
    logic         last_reg;

    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] out_prefix_reg;
    logic [B-1:0] out_byte_reg;
    logic         out_has_reg;
    logic         out_eos_reg;

    logic         accept;
    logic         hit;
    logic         need_out;
    logic         upd_go;
    logic         wr_en;
    logic [W-1:0] hit_idx;

    lz78e_pkg::cell_bus_t bus;

    logic [W-1:0] hit_chain [0:D-1];
    logic [D-1:0] match_vec;

    assign accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------------
    assign hit_chain[0] = '0;
    assign match_vec[0] = 1'b0;

    genvar k;
    generate
        for (k = 1; k < D; k++)
        begin : g_cell
            lz78e_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (W'(k)),
                .bus      (bus),
                .hit_in   (hit_chain[k-1]),
                .hit_out  (hit_chain[k]),
                .match    (match_vec[k])
            );
        end
    endgenerate

    assign hit_idx  = hit_chain[D-1];
    assign hit      = (hit_idx != '0);
    assign need_out = !hit || last_reg;
    assign upd_go   = (state_reg == lz78e_pkg::ST_UPDATE)
                      && (!need_out || !out_valid_reg || m_tready);
    assign wr_en    = upd_go && !hit && (count_reg < lz78e_pkg::LAST_ENTRY);

    always_comb
    begin
        bus.search    = accept;
        bus.node      = node_reg;
        bus.data      = s_tdata[B-1:0];
        bus.count     = count_reg;
        bus.wr_en     = wr_en;
        bus.wr_idx    = count_reg + W'(1);
        bus.wr_prefix = node_reg;
        bus.wr_byte   = byte_reg;
    end

    // ------------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lz78e_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lz78e_pkg::ST_UPDATE;
                end
            end
            lz78e_pkg::ST_UPDATE:
            begin
                if (upd_go)
                begin
                    state_next = lz78e_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lz78e_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        case (state_reg)
            lz78e_pkg::ST_IDLE:   s_tready = 1'b1;
            lz78e_pkg::ST_UPDATE: s_tready = 1'b0;
            default:              s_tready = 1'b0;
        endcase
    end

    always_comb
    begin
        node_next  = node_reg;
        count_next = count_reg;
        if (upd_go)
        begin
            if (last_reg)
            begin
                node_next  = '0;
                count_next = '0;
            end
            else
            begin
                node_next = hit ? hit_idx : '0;
                if (wr_en)
                begin
                    count_next = count_reg + W'(1);
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (upd_go && need_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lz78e_pkg::ST_IDLE;
            node_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            node_reg      <= node_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= s_tdata[B-1:0];
            last_reg <= s_tlast;
        end
        if (upd_go && need_out)
        begin
            // A final byte that extends a phrase flushes it without a byte.
            out_prefix_reg <= hit ? hit_idx : node_reg;
            out_byte_reg   <= hit ? '0 : byte_reg;
            out_has_reg    <= !hit;
            out_eos_reg    <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = lz78e_pkg::TDATA_OUT_W'({out_byte_reg, out_prefix_reg});
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_eos_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == lz78e_pkg::ST_UPDATE))
        else $error("accepted byte did not move to the update cycle");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lz78e_pkg::ST_UPDATE) |-> $onehot0(match_vec))
        else $error("more than one dictionary cell matched");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lz78e_pkg::LAST_ENTRY)
        else $error("entry count beyond dictionary size");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_go && last_reg) |=> ((count_reg == '0) && (node_reg == '0)))
        else $error("dictionary not cleared after the last byte");

endmodule

`default_nettype wire

// ===== bench/lz78_dictionary_encoder_tb.sv =====
// ============================================================================
// LZ78 dictionary encoder testbench
// Streams bytes into the encoder under random handshake gaps and checks every
// token against a dictionary predictor kept by a small scoreboard class.
// ============================================================================
`default_nettype none

module lz78_dictionary_encoder_tb;

    typedef struct packed {
        logic [lz78e_pkg::IDX_W-1:0]  prefix_index;
        logic [lz78e_pkg::BYTE_W-1:0] next_byte;
        logic                         has_byte;
        logic                         end_of_stream;
    } token_t;

    // Tracks the dictionary as the encoder should build it and holds the
    // tokens that are still due on the output.
    class lz78_token_scoreboard;
        logic [lz78e_pkg::IDX_W-1:0]  dict_prefix [lz78e_pkg::DICT_ENTRIES];
        logic [lz78e_pkg::BYTE_W-1:0] dict_byte [lz78e_pkg::DICT_ENTRIES];
        int unsigned                  dict_count;
        logic [lz78e_pkg::IDX_W-1:0]  node;
        token_t                       due_tokens [$];
        int                           errors;

        function new();
            dict_count = 0;
            node       = '0;
            errors     = 0;
        endfunction

        function int pending();
            return due_tokens.size();
        endfunction

        function void note_byte(logic [lz78e_pkg::BYTE_W-1:0] b, logic last);
            int unsigned hit;
            token_t      tok;
            hit = 0;
            for (int unsigned k = 1; k <= dict_count && k < lz78e_pkg::DICT_ENTRIES; k++)
            begin
                if (hit == 0 && dict_prefix[k] == node && dict_byte[k] == b)
                    hit = k;
            end
            if (hit != 0)
            begin
                node = lz78e_pkg::IDX_W'(hit);
                // A phrase still open at the end of the stream goes out without a byte.
                if (last)
                begin
                    tok = '{prefix_index: node, next_byte: '0, has_byte: 1'b0,
                            end_of_stream: 1'b1};
                    due_tokens.push_back(tok);
                end
            end
            else
            begin
                tok = '{prefix_index: node, next_byte: b, has_byte: 1'b1,
                        end_of_stream: last};
                due_tokens.push_back(tok);
                // Once full, the dictionary keeps its entries and stops growing.
                if (dict_count < lz78e_pkg::DICT_ENTRIES - 1)
                begin
                    dict_count++;
                    dict_prefix[dict_count] = node;
                    dict_byte[dict_count]   = b;
                end
                node = '0;
            end
            if (last)
            begin
                dict_count = 0;
                node       = '0;
            end
        endfunction

        function void check_token(logic [lz78e_pkg::TDATA_OUT_W-1:0] tdata, logic user,
                                  logic lst);
            token_t tok;
            token_t got;
            if (due_tokens.size() == 0)
            begin
                $display("%0t: unexpected token, expected none, actual tdata=%h",
                         $time, tdata, " tuser=%b tlast=%b", user, lst);
                errors++;
                return;
            end
            tok = due_tokens.pop_front();
            got = '{prefix_index: tdata[lz78e_pkg::IDX_W-1:0],
                    next_byte: tdata[lz78e_pkg::IDX_W +: lz78e_pkg::BYTE_W],
                    has_byte: user, end_of_stream: lst};
            if (got.prefix_index !== tok.prefix_index)
            begin
                $display("%0t: prefix_index mismatch, expected %0d, actual %0d",
                         $time, tok.prefix_index, got.prefix_index);
                errors++;
            end
            if (got.next_byte !== tok.next_byte)
            begin
                $display("%0t: next_byte mismatch, expected %h, actual %h",
                         $time, tok.next_byte, got.next_byte);
                errors++;
            end
            if (got.has_byte !== tok.has_byte)
            begin
                $display("%0t: has_byte mismatch, expected %b, actual %b",
                         $time, tok.has_byte, got.has_byte);
                errors++;
            end
            if (got.end_of_stream !== tok.end_of_stream)
            begin
                $display("%0t: end_of_stream mismatch, expected %b, actual %b",
                         $time, tok.end_of_stream, got.end_of_stream);
                errors++;
            end
            if (tdata[lz78e_pkg::TDATA_OUT_W-1:lz78e_pkg::IDX_W+lz78e_pkg::BYTE_W] !== '0)
            begin
                $display("%0t: tdata pad mismatch, expected 0, actual %b", $time,
                         tdata[lz78e_pkg::TDATA_OUT_W-1:lz78e_pkg::IDX_W+lz78e_pkg::BYTE_W]);
                errors++;
            end
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 1250;
    localparam int HOLD_CYCLES  = 300;

    logic                              clk;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [lz78e_pkg::TDATA_IN_W-1:0]  s_tdata;
    logic                              s_tlast;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [lz78e_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic                              m_tuser;
    logic                              m_tlast;

    lz78_token_scoreboard sb;

    int send_idle;
    int recv_idle;
    int items_sent;
    bit hold_req;

    lz78_dictionary_encoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Idle mix follows the item count: sender light and receiver heavy, then
    // the other way round, then no random idling after one long receiver hold.
    task automatic set_idle_mix();
        if (items_sent < RANDOM_ITEMS / 3)
        begin
            send_idle = 38;
            recv_idle = 72;
        end
        else if (items_sent < 2 * RANDOM_ITEMS / 3)
        begin
            send_idle = 72;
            recv_idle = 38;
        end
        else
        begin
            if (send_idle != 0)
                hold_req = 1'b1;
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    task automatic send_byte(input logic [lz78e_pkg::BYTE_W-1:0] b, input logic last,
                             input bit final_item);
        set_idle_mix();
        s_tvalid <= 1'b1;
        s_tdata  <= lz78e_pkg::TDATA_IN_W'(b);
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_byte(b, last);
        items_sent++;
        if (final_item || $urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle)
                @(posedge clk);
        end
    endtask

    // One stream ends with its last byte flagged; the dictionary starts over.
    task automatic send_stream(input int len, input int alpha_size, input bit wide);
        logic [lz78e_pkg::BYTE_W-1:0] symbols [8];
        logic [lz78e_pkg::BYTE_W-1:0] b;
        foreach (symbols[i])
            symbols[i] = lz78e_pkg::BYTE_W'($urandom_range(0, 255));
        for (int i = 0; i < len; i++)
        begin
            if (wide)
                b = lz78e_pkg::BYTE_W'($urandom_range(0, 255));
            else
                b = symbols[$urandom_range(0, alpha_size - 1)];
            send_byte(b, i == len - 1, 1'b0);
        end
    endtask

    // Receiver: checks each transaction and picks tready for the next edge.
    initial
    begin
        int hold_cnt;
        hold_cnt = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_token(m_tdata, m_tuser, m_tlast);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    initial
    begin
        int len;
        bit wide;
        sb         = new();
        send_idle  = 38;
        recv_idle  = 72;
        items_sent = 0;
        hold_req   = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-byte streams at the value extremes.
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b0);
        // Growing phrases; the stream ends on a byte that misses.
        send_byte(8'h41, 1'b0, 1'b0);
        send_byte(8'h42, 1'b0, 1'b0);
        send_byte(8'h41, 1'b0, 1'b0);
        send_byte(8'h42, 1'b0, 1'b0);
        send_byte(8'h41, 1'b0, 1'b0);
        send_byte(8'h42, 1'b0, 1'b0);
        send_byte(8'h41, 1'b1, 1'b0);
        // Two streams end while a phrase is still open, one level deep in each.
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b1, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'h55, 1'b1, 1'b0);
        // The dictionary from the previous stream must be gone.
        send_byte(8'h55, 1'b1, 1'b0);

        // First random stream is long enough to fill the dictionary.
        send_stream(300, 8, 1'b1);
        while (items_sent < RANDOM_ITEMS)
        begin
            wide = ($urandom_range(0, 7) == 0);
            if (wide)
                len = $urandom_range(200, 320);
            else
                len = $urandom_range(1, 40);
            // The last stream is cut short so the item total lands on target.
            if (len > RANDOM_ITEMS - items_sent)
                len = RANDOM_ITEMS - items_sent;
            send_stream(len, $urandom_range(1, 8), wide);
        end
        send_byte(lz78e_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
